@@ sv/wvpa_pkg.sv @@
// shared types, constants and table functions of the water vapor pressure pipeline
`default_nettype none
package wvpa_pkg;

    // per-word side flags that travel with the data
    typedef struct packed {
        logic high;   // high coefficient set in use
        logic oor;    // temperature outside 1..374 C
        logic zero;   // C+t not positive, pressure forced to 0
    } wvpa_flags_t;

    // temperature thresholds on the raw kelvin Q8 input
    localparam logic [17:0] HIGH_MIN = 18'd97643;
    localparam logic [17:0] OOR_LO   = 18'd70182;
    localparam logic [17:0] OOR_HI   = 18'd165671;

    // C+t offsets in 1/256000 degree units
    localparam logic [27:0] OFF_LO = 28'd10169344;
    localparam logic [27:0] OFF_HI = 28'd7338240;

    // B*1000*8 for the divider range check
    localparam logic [27:0] BM8_LO = 28'd13845040;
    localparam logic [27:0] BM8_HI = 28'd14487520;

    // A*100000
    localparam logic [63:0] AM_LO = 64'd807131;
    localparam logic [63:0] AM_HI = 64'd814019;

    localparam logic signed [30:0] LOG2_10_Q28 = 31'sd891723283;
    localparam logic [63:0]        LN2_Q30     = 64'd744261118;
    localparam logic [63:0]        HALF_Q30    = 64'd536870912;
    localparam logic [63:0]        ONE_Q30     = 64'd1073741824;

    // pascal conversion: p = round(m*5065 / (38*2^s))
    localparam logic [44:0] PA_NUM   = 45'd5065;
    localparam logic [45:0] PA_BIAS  = 46'd19;
    localparam logic [45:0] PA_LIMIT = 46'd1275068416;
    localparam logic [63:0] RECIP_19 = (64'd34359738368 + 64'd18) / 64'd19;
    localparam logic [24:0] PA_MAX   = 25'h1FFFFFF;

    // integer square root, elaboration use only
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bit_v;
        rem   = v;
        res   = '0;
        bit_v = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++)
        begin
            if (rem >= res + bit_v)
            begin
                rem = rem - (res + bit_v);
                res = (res >> 1) + bit_v;
            end
            else
            begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // 2^(2^-k) in Q30 by repeated square roots
    function automatic logic [63:0] root_q30(input int k);
        logic [63:0] g;
        g = 64'd2147483648;
        for (int j = 1; j <= 14; j++)
        begin
            if (j <= k)
            begin
                g = isqrt64(g << 30);
            end
        end
        return g;
    endfunction

endpackage
`default_nettype wire

@@ sv/wvpa_div.sv @@
// front end and bit-per-stage restoring divider for B/(C+t)
`default_nettype none
module wvpa_div #(
    parameter int FB = 20
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    input  wire  [17:0]             temp,
    output logic                    out_valid,
    output wvpa_pkg::wvpa_flags_t   out_flags,
    output logic [FB+4:0]           quot
);
    localparam int QB = FB + 5;

    // front stage: set select, range flags, denominator
    logic [27:0]           prod0;
    logic [27:0]           off0;
    wvpa_pkg::wvpa_flags_t flags0;
    assign prod0       = 28'(28'(temp) * 28'd1000);
    assign flags0.high = temp >= wvpa_pkg::HIGH_MIN;
    assign flags0.oor  = (temp <= wvpa_pkg::OOR_LO) || (temp >= wvpa_pkg::OOR_HI);
    assign off0        = flags0.high ? wvpa_pkg::OFF_HI : wvpa_pkg::OFF_LO;
    assign flags0.zero = prod0 <= off0;

    logic                  v0_reg;
    wvpa_pkg::wvpa_flags_t f0_reg;
    logic [27:0]           dk0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        f0_reg  <= flags0;
        dk0_reg <= prod0 - off0;
    end

    // divider stages; index 0 holds the range check
    logic                  v_reg  [0:QB];
    wvpa_pkg::wvpa_flags_t f_reg  [0:QB];
    logic                  sat_reg[0:QB];
    logic [27:0]           dk_reg [0:QB];
    logic [28:0]           r_reg  [0:QB];
    logic [QB-1:0]         q_reg  [0:QB];

    logic [27:0] bm8;
    assign bm8 = f0_reg.high ? wvpa_pkg::BM8_HI : wvpa_pkg::BM8_LO;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else
            v_reg[0] <= v0_reg;
    end

    always_ff @(posedge clk)
    begin
        f_reg[0]   <= f0_reg;
        sat_reg[0] <= bm8 >= dk0_reg;
        dk_reg[0]  <= dk0_reg;
        r_reg[0]   <= {1'b0, bm8};
        q_reg[0]   <= '0;
    end

    for (genvar i = 0; i < QB; i++)
    begin : g_step
        logic [28:0]   r2;
        logic          ge;
        logic [28:0]   r_next;
        logic [QB-1:0] q_next;

        // one quotient bit per stage
        always_comb
        begin
            r2     = {r_reg[i][27:0], 1'b0};
            ge     = r2 >= {1'b0, dk_reg[i]};
            r_next = ge ? (r2 - {1'b0, dk_reg[i]}) : r2;
            q_next = {q_reg[i][QB-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else
                v_reg[i+1] <= v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            f_reg[i+1]   <= f_reg[i];
            sat_reg[i+1] <= sat_reg[i];
            dk_reg[i+1]  <= dk_reg[i];
            r_reg[i+1]   <= r_next;
            q_reg[i+1]   <= q_next;
        end
    end

    assign out_valid = v_reg[QB];
    assign out_flags = f_reg[QB];
    assign quot      = sat_reg[QB] ? '1 : q_reg[QB];

endmodule
`default_nettype wire

@@ sv/wvpa_exp2.sv @@
// exponent, log2(10) scaling and exp2 table stages
`default_nettype none
module wvpa_exp2 #(
    parameter int FB  = 20,
    parameter int ETB = 10
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    input  wire  wvpa_pkg::wvpa_flags_t in_flags,
    input  wire  [FB+4:0]           quot,
    output logic                    out_valid,
    output wvpa_pkg::wvpa_flags_t   out_flags,
    output logic [31:0]             mant,
    output logic signed [6:0]       expo
);
    localparam int H   = (ETB < FB) ? ETB : FB;
    localparam int RW  = FB - H;
    localparam int RWX = (RW > 0) ? RW : 1;

    localparam logic [63:0] AQ_LO = ((wvpa_pkg::AM_LO << FB) + 64'd50000) / 64'd100000;
    localparam logic [63:0] AQ_HI = ((wvpa_pkg::AM_HI << FB) + 64'd50000) / 64'd100000;
    localparam logic signed [FB+6:0] EMAX = (FB+7)'((64'd8 << FB) - 64'd1);
    localparam logic signed [FB+6:0] EMIN = -(FB+7)'(64'd8 << FB);

    // stage a: exponent A - Q with clamp
    logic signed [FB+6:0] diff_a;
    logic signed [FB+3:0] e_a;
    always_comb
    begin
        diff_a = (in_flags.high ? (FB+7)'(AQ_HI) : (FB+7)'(AQ_LO))
                 - $signed({2'b00, quot});
        if (diff_a > EMAX)
            e_a = EMAX[FB+3:0];
        else if (diff_a < EMIN)
            e_a = EMIN[FB+3:0];
        else
            e_a = diff_a[FB+3:0];
    end

    logic                  va_reg;
    wvpa_pkg::wvpa_flags_t fa_reg;
    logic signed [FB+3:0]  e_reg;

    // stage b: times log2(10)
    logic signed [FB+34:0] pb;
    logic signed [30:0]    l_c;
    assign l_c = wvpa_pkg::LOG2_10_Q28;
    assign pb  = e_reg * l_c;

    logic                  vb_reg;
    wvpa_pkg::wvpa_flags_t fb_reg;
    logic signed [FB+34:0] pb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        fa_reg <= in_flags;
        e_reg  <= e_a;
        fb_reg <= fa_reg;
        pb_reg <= pb;
    end

    // stage c and table stages: index 0 holds the split of y
    logic                  v_reg[0:H];
    wvpa_pkg::wvpa_flags_t f_reg[0:H];
    logic [31:0]           m_reg[0:H];
    logic [FB-1:0]         fr_reg[0:H];
    logic signed [6:0]     n_reg[0:H];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else
            v_reg[0] <= vb_reg;
    end

    always_ff @(posedge clk)
    begin
        f_reg[0]  <= fb_reg;
        m_reg[0]  <= wvpa_pkg::ONE_Q30[31:0];
        fr_reg[0] <= pb_reg[FB+27:28];
        n_reg[0]  <= pb_reg[FB+34:FB+28];
    end

    for (genvar i = 0; i < H; i++)
    begin : g_tab
        localparam logic [63:0] G = wvpa_pkg::root_q30(i + 1);
        logic [63:0] prod;
        logic [63:0] rnd;
        logic [31:0] m_next;

        // multiply by 2^(2^-k) when that fraction bit is set
        always_comb
        begin
            prod   = 64'(m_reg[i]) * G;
            rnd    = (prod + wvpa_pkg::HALF_Q30) >> 30;
            m_next = fr_reg[i][FB-1-i] ? rnd[31:0] : m_reg[i];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else
                v_reg[i+1] <= v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            f_reg[i+1]  <= f_reg[i];
            m_reg[i+1]  <= m_next;
            fr_reg[i+1] <= fr_reg[i];
            n_reg[i+1]  <= n_reg[i];
        end
    end

    // linear correction for the low fraction bits
    logic [RWX-1:0] rem_c;
    if (RW > 0)
    begin : g_rem
        assign rem_c = fr_reg[H][RWX-1:0];
    end
    else
    begin : g_norem
        assign rem_c = '0;
    end

    logic [63:0] mr_c;
    assign mr_c = (64'(m_reg[H]) * 64'(rem_c)) >> FB;

    logic                  vc_reg;
    wvpa_pkg::wvpa_flags_t fc_reg;
    logic [31:0]           mc_reg;
    logic [31:0]           corr_reg;
    logic signed [6:0]     nc_reg;

    logic [63:0] add_c;
    assign add_c = (64'(corr_reg) * wvpa_pkg::LN2_Q30 + wvpa_pkg::HALF_Q30) >> 30;

    logic                  vd_reg;
    wvpa_pkg::wvpa_flags_t fd_reg;
    logic [31:0]           md_reg;
    logic signed [6:0]     nd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else
        begin
            vc_reg <= v_reg[H];
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        fc_reg   <= f_reg[H];
        mc_reg   <= m_reg[H];
        corr_reg <= mr_c[31:0];
        nc_reg   <= n_reg[H];
        fd_reg   <= fc_reg;
        md_reg   <= mc_reg + add_c[31:0];
        nd_reg   <= nc_reg;
    end

    assign out_valid = vd_reg;
    assign out_flags = fd_reg;
    assign mant      = md_reg;
    assign expo      = nd_reg;

endmodule
`default_nettype wire

@@ sv/wvpa_scale.sv @@
// mmHg to pascal scaling, rounding and saturation
`default_nettype none
module wvpa_scale (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    input  wire  wvpa_pkg::wvpa_flags_t in_flags,
    input  wire  [31:0]             mant,
    input  wire  signed [6:0]       expo,
    output logic                    out_valid,
    output logic [24:0]             pressure,
    output logic                    high,
    output logic                    oor
);
    // stage 1: m*5065 and shift count 30-n
    logic                  v1_reg;
    wvpa_pkg::wvpa_flags_t f1_reg;
    logic [44:0]           num_reg;
    logic signed [7:0]     s_reg;

    // stage 2: shift with rounding bias, saturation check
    logic [45:0] t_c;
    always_comb
    begin
        if (s_reg > 8'sd49)
            t_c = '0;
        else
            t_c = 46'(num_reg >> s_reg[5:0]) + wvpa_pkg::PA_BIAS;
    end

    logic                  v2_reg;
    wvpa_pkg::wvpa_flags_t f2_reg;
    logic [30:0]           t_reg;
    logic                  sat_reg;

    // stage 3: divide by 38 as halve then reciprocal of 19
    logic [63:0] q_c;
    assign q_c = (64'(t_reg[30:1]) * wvpa_pkg::RECIP_19) >> 35;

    logic        v3_reg;
    logic [24:0] p_reg;
    logic        h_reg;
    logic        o_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        f1_reg  <= in_flags;
        num_reg <= 45'(mant) * wvpa_pkg::PA_NUM;
        s_reg   <= 8'sd30 - 8'(expo);
        f2_reg  <= f1_reg;
        t_reg   <= t_c[30:0];
        sat_reg <= t_c >= wvpa_pkg::PA_LIMIT;
        h_reg   <= f2_reg.high;
        o_reg   <= f2_reg.oor;
        if (f2_reg.zero)
            p_reg <= '0;
        else if (sat_reg)
            p_reg <= wvpa_pkg::PA_MAX;
        else
            p_reg <= q_c[24:0];
    end

    assign out_valid = v3_reg;
    assign pressure  = p_reg;
    assign high      = h_reg;
    assign oor       = o_reg;

endmodule
`default_nettype wire

@@ sv/water_vapor_pressure_antoine_top.sv @@
// top level of the antoine water vapor pressure pipeline
// One temperature word enters per clock; busy stays low, so a word is taken whenever
// start is high. Each result appears for one cycle with done, in input order. The
// pipeline depth is set by the divider, which resolves one quotient bit per stage
// over FRACTION_BITS + 5 stages, and by the exp2 table, one multiplier stage per
// table bit. The receiver cannot stall the block.
`default_nettype none
module water_vapor_pressure_antoine_top #(
    parameter int EXP_TABLE_BITS = 10,
    parameter int FRACTION_BITS  = 20
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [17:0] temp_kelvin_q8,
    output logic        done,
    output logic [24:0] pressure_pa,
    output logic        high_range_set,
    output logic        out_of_range
);
    logic                    div_valid;
    wvpa_pkg::wvpa_flags_t   div_flags;
    logic [FRACTION_BITS+4:0] div_quot;
    logic                    exp_valid;
    wvpa_pkg::wvpa_flags_t   exp_flags;
    logic [31:0]             exp_mant;
    logic signed [6:0]       exp_expo;

    // fully pipelined, never holds off a word
    assign busy = 1'b0;

    wvpa_div #(.FB(FRACTION_BITS)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .temp     (temp_kelvin_q8),
        .out_valid(div_valid),
        .out_flags(div_flags),
        .quot     (div_quot)
    );

    wvpa_exp2 #(.FB(FRACTION_BITS), .ETB(EXP_TABLE_BITS)) u_exp2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (div_valid),
        .in_flags (div_flags),
        .quot     (div_quot),
        .out_valid(exp_valid),
        .out_flags(exp_flags),
        .mant     (exp_mant),
        .expo     (exp_expo)
    );

    wvpa_scale u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (exp_valid),
        .in_flags (exp_flags),
        .mant     (exp_mant),
        .expo     (exp_expo),
        .out_valid(done),
        .pressure (pressure_pa),
        .high     (high_range_set),
        .oor      (out_of_range)
    );

endmodule
`default_nettype wire

@@ sv/wvpa_check.sv @@
// port-level checker for the vapor pressure pipeline and its bind
`default_nettype none
module wvpa_check #(
    parameter int FB  = 20,
    parameter int ETB = 10
) (
    input wire        clk,
    input wire        rst_n,
    input wire        start,
    input wire        busy,
    input wire [17:0] temp_kelvin_q8,
    input wire        done,
    input wire [24:0] pressure_pa,
    input wire        high_range_set,
    input wire        out_of_range
);
    localparam int LAT = FB + ((ETB < FB) ? ETB : FB) + 15;

    // every result traces back to a word taken a fixed latency earlier
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without a matching start");

    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised on a pipeline that never stalls");

    // coefficient set follows the temperature of the same word
    a_set_sel: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (high_range_set == ($past(temp_kelvin_q8, LAT) >= wvpa_pkg::HIGH_MIN)))
        else $error("coefficient set does not match temperature");

    // inside 1..374 C the pressure is never zero
    a_in_range_nz: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !out_of_range) |-> (pressure_pa != 25'd0))
        else $error("zero pressure inside the valid range");

endmodule

bind water_vapor_pressure_antoine_top wvpa_check #(
    .FB (FRACTION_BITS),
    .ETB(EXP_TABLE_BITS)
) u_wvpa_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .temp_kelvin_q8(temp_kelvin_q8),
    .done          (done),
    .pressure_pa   (pressure_pa),
    .high_range_set(high_range_set),
    .out_of_range  (out_of_range)
);
`default_nettype wire

@@ sim/tb_water_vapor_pressure_antoine_top.sv @@
// testbench for the antoine water vapor pressure pipeline, checked against a fixed-point predictor
`default_nettype none
module tb_water_vapor_pressure_antoine_top;

    localparam int EXP_BITS  = 10;
    localparam int FRAC_BITS = 20;
    localparam int LATENCY   = FRAC_BITS + EXP_BITS + 15;
    localparam int N_RANDOM  = 1730;

    // one expected pressure word
    typedef struct {
        logic [24:0] pa;
        logic        high;
        logic        oor;
    } pressure_word_t;

    // directed row: input, whether the expectation is typed in, and that expectation
    typedef struct {
        logic [17:0]    temp;
        bit             typed;
        pressure_word_t want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [17:0] temp_kelvin_q8;
    logic        done;
    logic [24:0] pressure_pa;
    logic        high_range_set;
    logic        out_of_range;

    pressure_word_t pending_words[$];
    int             error_count;

    water_vapor_pressure_antoine_top #(
        .EXP_TABLE_BITS(EXP_BITS),
        .FRACTION_BITS(FRAC_BITS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .temp_kelvin_q8(temp_kelvin_q8),
        .done(done),
        .pressure_pa(pressure_pa),
        .high_range_set(high_range_set),
        .out_of_range(out_of_range)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // floor of a signed value over 2^s
    function automatic longint floor_div_pow2(input longint v, input int s);
        longint mag;
        if (v >= 0)
            return v >>> s;
        mag = -v;
        return -((mag + ((64'sd1 <<< s) - 1)) >>> s);
    endfunction

    // bitwise integer square root
    function automatic longint unsigned isqrt_tb(input longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // saturation vapor pressure of one temperature word
    function automatic pressure_word_t vapor_pressure(input logic [17:0] tk);
        pressure_word_t w;
        longint dk, aq, q, e, y, n, s;
        longint unsigned bm, am, f, fhi, r, m, corr, num, den, p, g;
        int hb;
        w.high = (tk >= wvpa_pkg::HIGH_MIN);
        w.oor  = (tk <= wvpa_pkg::OOR_LO) || (tk >= wvpa_pkg::OOR_HI);
        w.pa   = '0;
        hb = (EXP_BITS < FRAC_BITS) ? EXP_BITS : FRAC_BITS;
        dk = longint'(tk) * 1000
             - (w.high ? longint'(wvpa_pkg::OFF_HI) : longint'(wvpa_pkg::OFF_LO));
        bm = w.high ? 64'd1810940 : 64'd1730630;
        am = w.high ? wvpa_pkg::AM_HI : wvpa_pkg::AM_LO;
        if (dk > 0)
        begin
            aq = longint'(((am << FRAC_BITS) + 64'd50000) / 64'd100000);
            q  = longint'(((bm * 256) << FRAC_BITS) / longint'(dk));
            e  = aq - q;
            if (e > (64'sd8 <<< FRAC_BITS) - 1) e = (64'sd8 <<< FRAC_BITS) - 1;
            if (e < -(64'sd8 <<< FRAC_BITS))    e = -(64'sd8 <<< FRAC_BITS);
            y = floor_div_pow2(e * 64'sd891723283, 28);
            n = floor_div_pow2(y, FRAC_BITS);
            f = y - (n <<< FRAC_BITS);
            fhi = f >> (FRAC_BITS - hb);
            r   = f & ((64'd1 << (FRAC_BITS - hb)) - 1);
            m   = wvpa_pkg::ONE_Q30;
            g   = 64'd2147483648;
            // walk the root table, one square root per fraction bit
            for (int k = 1; k <= hb; k++)
            begin
                g = isqrt_tb(g << 30);
                if ((fhi >> (hb - k)) & 1)
                    m = (m * g + wvpa_pkg::HALF_Q30) >> 30;
            end
            corr = (m * r) >> FRAC_BITS;
            m    = m + ((corr * wvpa_pkg::LN2_Q30 + wvpa_pkg::HALF_Q30) >> 30);
            s = 30 - n;
            if (s < 0)
                w.pa = wvpa_pkg::PA_MAX;
            else if (s < 50)
            begin
                num = m * 5065;
                den = 64'd38 << s;
                p   = (num + den / 2) / den;
                w.pa = (p > 64'(wvpa_pkg::PA_MAX)) ? wvpa_pkg::PA_MAX : p[24:0];
            end
        end
        return w;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        pressure_word_t w;
        if (rst_n && done)
        begin
            if (pending_words.size() == 0)
                report_mismatch("unexpected word", pressure_pa, 0);
            else
            begin
                w = pending_words.pop_front();
                if (pressure_pa !== w.pa)
                    report_mismatch("pressure_pa", pressure_pa, w.pa);
                if (high_range_set !== w.high)
                    report_mismatch("high_range_set", high_range_set, w.high);
                if (out_of_range !== w.oor)
                    report_mismatch("out_of_range", out_of_range, w.oor);
            end
        end
    end

    // hand one word to the block, after the requested gap
    task automatic send_word(input logic [17:0] tk, input pressure_word_t want, input int gap);
        for (int i = 0; i < gap; i++)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start          <= 1'b1;
        temp_kelvin_q8 <= tk;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_words.push_back(want);
    endtask

    // random temperature, mostly in the physical range with steps around the edges and near C+t = 0
    function automatic logic [17:0] random_temp();
        case ($urandom_range(0, 9))
            0: return 18'($urandom);
            1: return 18'($urandom_range(0, 2 * 40000));
            2: return wvpa_pkg::HIGH_MIN + 18'($urandom_range(0, 8)) - 18'd4;
            3: return wvpa_pkg::OOR_LO + 18'($urandom_range(0, 8)) - 18'd4;
            4: return wvpa_pkg::OOR_HI + 18'($urandom_range(0, 8)) - 18'd4;
            5: return 18'($urandom_range(10160, 10180));
            default: return 18'($urandom_range(wvpa_pkg::OOR_LO, wvpa_pkg::OOR_HI));
        endcase
    endfunction

    // stimulus
    initial
    begin
        stim_row_t      rows[$];
        pressure_word_t w;
        logic [17:0]    tk;
        int             gap;
        bit             burst;
        rst_n          = 1'b0;
        start          = 1'b0;
        temp_kelvin_q8 = '0;
        error_count    = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows: zero pressure below C+t, extremes, set switch, range edges
        rows.push_back('{18'd0,      1'b1, '{25'd0, 1'b0, 1'b1}});
        rows.push_back('{18'd10169,  1'b1, '{25'd0, 1'b0, 1'b1}});
        rows.push_back('{18'd10170,  1'b0, '{25'd0, 1'b0, 1'b0}});
        rows.push_back('{18'd20000,  1'b0, '{25'd0, 1'b0, 1'b0}});
        rows.push_back('{wvpa_pkg::OOR_LO,       1'b0, '{25'd0, 1'b0, 1'b0}});
        rows.push_back('{wvpa_pkg::OOR_LO + 1,   1'b0, '{25'd0, 1'b0, 1'b0}});
        rows.push_back('{18'd95949,  1'b0, '{25'd0, 1'b0, 1'b0}});
        rows.push_back('{wvpa_pkg::HIGH_MIN - 1, 1'b0, '{25'd0, 1'b0, 1'b0}});
        rows.push_back('{wvpa_pkg::HIGH_MIN,     1'b0, '{25'd0, 1'b0, 1'b0}});
        rows.push_back('{wvpa_pkg::OOR_HI - 1,   1'b0, '{25'd0, 1'b0, 1'b0}});
        rows.push_back('{wvpa_pkg::OOR_HI,       1'b0, '{25'd0, 1'b0, 1'b0}});
        rows.push_back('{18'd200000, 1'b0, '{25'd0, 1'b0, 1'b0}});
        rows.push_back('{18'h3FFFF,  1'b1, '{wvpa_pkg::PA_MAX, 1'b1, 1'b1}});
        rows.push_back('{18'h2AAAA,  1'b0, '{25'd0, 1'b0, 1'b0}});
        rows.push_back('{18'h15555,  1'b0, '{25'd0, 1'b0, 1'b0}});
        foreach (rows[i])
        begin
            w = rows[i].typed ? rows[i].want : vapor_pressure(rows[i].temp);
            send_word(rows[i].temp, w, (i % 3 == 0) ? 1 : 0);
        end

        // random part, with bursts that never idle
        burst = 1'b0;
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i % 50 == 0)
                burst = ($urandom_range(0, 2) == 0);
            // drain the pipeline once before sending again
            if (i == N_RANDOM / 2)
            begin
                start <= 1'b0;
                @(posedge clk);
                while (pending_words.size() != 0)
                    @(posedge clk);
            end
            tk  = random_temp();
            gap = burst ? 0 : $urandom_range(0, 16);
            send_word(tk, vapor_pressure(tk), gap);
        end
        start <= 1'b0;

        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // run limit
    initial
    begin
        #1000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
`default_nettype wire
